// File: src/cul_pkg.sv
// Package for the category usage ledger: field widths, status codes,
// controller states and the update result bundle. Depends on nothing.
package cul_pkg;

	localparam int unsigned DEF_SLOTS = 32;
	localparam int unsigned ID_W      = 16;
	localparam int unsigned BYTES_W   = 64;
	localparam int unsigned PEAK_W    = 63;
	localparam int unsigned IDX_W     = 5;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_IGNORED = 2'd1,
		ST_DROPPED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_UPDATE
	} state_t;

	typedef struct packed {
		logic [BYTES_W-1:0] cat_bytes;
		logic [PEAK_W-1:0]  cat_peak;
		logic [BYTES_W-1:0] total;
		logic [PEAK_W-1:0]  total_peak;
	} upd_t;

endpackage

// File: src/category_usage_ledger.sv
// Category usage ledger top level: slot key and slot data memories, the scan
// controller and the result registers. Depends on cul_pkg and cul_update.
//
// A transaction is offered by raising start with category_id and delta_bytes;
// it is taken at a rising edge where start is high and busy is low. Exactly
// one result follows, shown for a single cycle with done high; the receiver
// cannot hold it off, so it must take it in that cycle.
// A zero delta is answered in the cycle after acceptance and busy stays low.
// Otherwise the block looks the id up by reading the key memory one slot per
// cycle, then reads the slot's count and peak from the data memory and
// writes them back updated. A hit stops the scan at that slot, while a miss
// or a drop on a full table scans every slot in use; the worst case is a hit
// on the last slot, set by the single key memory port.
// busy falls in the cycle that done rises, so a new transaction can be taken
// while the previous result is on the ports.
// A miss claims the next free slot; when every slot is taken the event is
// dropped with status 2 and nothing changes.
// Reset clears the slot count, the grand total and its peak; the memories
// are not cleared since a slot is only read after it has been claimed.
module category_usage_ledger #(
	parameter int unsigned SLOTS = cul_pkg::DEF_SLOTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [cul_pkg::ID_W-1:0]     category_id,
	input  logic [cul_pkg::BYTES_W-1:0]  delta_bytes,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [cul_pkg::IDX_W-1:0]    slot_index,
	output logic [cul_pkg::BYTES_W-1:0]  category_bytes,
	output logic [cul_pkg::PEAK_W-1:0]   category_peak,
	output logic [cul_pkg::BYTES_W-1:0]  total_bytes,
	output logic [cul_pkg::PEAK_W-1:0]   total_peak
);
	import cul_pkg::*;

	localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW    = $clog2(SLOTS + 1);
	localparam int unsigned EXT_W = (AW > IDX_W) ? AW : IDX_W;
	localparam int unsigned DW    = BYTES_W + PEAK_W;

	// Slot memories: one holds the keys, the other a count and peak pair.
	logic [ID_W-1:0] key_mem  [SLOTS];
	logic [DW-1:0]   data_mem [SLOTS];
	logic [ID_W-1:0] key_rdata_q;
	logic [DW-1:0]   data_rdata_q;

	state_t state_q, state_d;

	logic [ID_W-1:0]    id_q;
	logic [BYTES_W-1:0] delta_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      used_q;
	logic               cmp_vld_s1;
	logic [AW-1:0]      cmp_addr_s1;
	logic [AW-1:0]      slot_q;
	logic               fresh_q;
	logic [BYTES_W-1:0] total_q;
	logic [PEAK_W-1:0]  tpeak_q;

	logic               done_q;
	status_t            status_q;
	logic [IDX_W-1:0]   slot_index_q;
	logic [BYTES_W-1:0] cat_bytes_q;
	logic [PEAK_W-1:0]  cat_peak_q;
	logic [BYTES_W-1:0] total_bytes_q;
	logic [PEAK_W-1:0]  total_peak_q;

	// Controller decisions, decoded from the present state.
	logic accept;
	logic hit;
	logic scan_done;
	logic full;
	logic issue;
	logic data_re;
	logic wr_en;

	logic [BYTES_W-1:0] old_bytes;
	logic [PEAK_W-1:0]  old_peak;
	upd_t               upd;
	logic [EXT_W-1:0]   slot_ext;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Output decode of the controller.
	always_comb begin
		full      = (used_q == CW'(SLOTS));
		hit       = 1'b0;
		scan_done = 1'b0;
		issue     = 1'b0;
		data_re   = 1'b0;
		wr_en     = 1'b0;
		case (state_q)
			S_SCAN: begin
				hit       = cmp_vld_s1 && (key_rdata_q == id_q);
				scan_done = !cmp_vld_s1 && (cnt_q >= used_q);
				issue     = !hit && (cnt_q < used_q);
			end
			S_READ: begin
				data_re = 1'b1;
			end
			S_UPDATE: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Next-state decode.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (delta_bytes != '0)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_READ;
				end else if (scan_done) begin
					state_d = full ? S_IDLE : S_UPDATE;
				end
			end
			S_READ: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// A freshly claimed slot starts from a zero count and peak, so its stale
	// memory contents are never used.
	assign old_bytes = fresh_q ? '0 : data_rdata_q[DW-1:PEAK_W];
	assign old_peak  = fresh_q ? '0 : data_rdata_q[PEAK_W-1:0];
	assign slot_ext  = EXT_W'(slot_q);

	cul_update u_update (
		.old_bytes      (old_bytes),
		.old_peak       (old_peak),
		.old_total      (total_q),
		.old_total_peak (tpeak_q),
		.delta          (delta_q),
		.res            (upd)
	);

	// Memory ports. Reads and writes of one transaction never overlap on the
	// same entry, since the next lookup starts only after the write-back.
	always_ff @(posedge clk) begin
		if (issue) begin
			key_rdata_q <= key_mem[cnt_q[AW-1:0]];
		end
		if (data_re) begin
			data_rdata_q <= data_mem[slot_q];
		end
		if (wr_en) begin
			data_mem[slot_q] <= {upd.cat_bytes, upd.cat_peak};
			if (fresh_q) begin
				key_mem[slot_q] <= id_q;
			end
		end
	end

	// Control state and ledger totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			used_q     <= '0;
			total_q    <= '0;
			tpeak_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && (delta_bytes == '0)) || (scan_done && full) || wr_en;
			if (accept) begin
				cnt_q      <= '0;
				cmp_vld_s1 <= 1'b0;
			end else if (state_q == S_SCAN) begin
				cmp_vld_s1 <= issue;
				if (issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (wr_en) begin
				total_q <= upd.total;
				tpeak_q <= upd.total_peak;
				if (fresh_q) begin
					used_q <= used_q + 1'b1;
				end
			end
		end
	end

	// Transaction payload, scan pipeline address and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q    <= category_id;
			delta_q <= delta_bytes;
		end
		if (issue) begin
			cmp_addr_s1 <= cnt_q[AW-1:0];
		end
		if (hit) begin
			slot_q  <= cmp_addr_s1;
			fresh_q <= 1'b0;
		end else if (scan_done && !full) begin
			slot_q  <= used_q[AW-1:0];
			fresh_q <= 1'b1;
		end
		if (wr_en) begin
			status_q      <= ST_UPDATED;
			slot_index_q  <= slot_ext[IDX_W-1:0];
			cat_bytes_q   <= upd.cat_bytes;
			cat_peak_q    <= upd.cat_peak;
			total_bytes_q <= upd.total;
			total_peak_q  <= upd.total_peak;
		end else if ((accept && (delta_bytes == '0)) || (scan_done && full)) begin
			status_q      <= accept ? ST_IGNORED : ST_DROPPED;
			slot_index_q  <= '0;
			cat_bytes_q   <= '0;
			cat_peak_q    <= '0;
			total_bytes_q <= total_q;
			total_peak_q  <= tpeak_q;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign slot_index     = slot_index_q;
	assign category_bytes = cat_bytes_q;
	assign category_peak  = cat_peak_q;
	assign total_bytes    = total_bytes_q;
	assign total_peak     = total_peak_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(SLOTS))
		else $error("slot count exceeds the table size");

	a_update_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPDATE |=> done && status == ST_UPDATED)
		else $error("write-back not followed by an updated result");

	a_updated_src: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_UPDATED |-> $past(state_q == S_UPDATE))
		else $error("updated result without a write-back");

	a_claim_step: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != $past(used_q) |-> $past(state_q == S_UPDATE && fresh_q)
			&& used_q == $past(used_q) + 1'b1)
		else $error("slot count changed outside a claim");

endmodule

// File: src/cul_update.sv
// Update arithmetic of the ledger: adds the delta to a category count and to
// the grand total and raises both high-water marks. Depends on cul_pkg.
module cul_update (
	input  logic [cul_pkg::BYTES_W-1:0] old_bytes,
	input  logic [cul_pkg::PEAK_W-1:0]  old_peak,
	input  logic [cul_pkg::BYTES_W-1:0] old_total,
	input  logic [cul_pkg::PEAK_W-1:0]  old_total_peak,
	input  logic [cul_pkg::BYTES_W-1:0] delta,
	output cul_pkg::upd_t               res
);
	import cul_pkg::*;

	logic [BYTES_W-1:0] new_bytes;
	logic [BYTES_W-1:0] new_total;

	// Peaks are never negative, so a signed greater-than against them is a
	// clear sign bit and a larger magnitude field.
	always_comb begin
		new_bytes         = old_bytes + delta;
		new_total         = old_total + delta;
		res.cat_bytes     = new_bytes;
		res.total         = new_total;
		res.cat_peak      = old_peak;
		res.total_peak    = old_total_peak;
		if (!new_bytes[BYTES_W-1] && (new_bytes[PEAK_W-1:0] > old_peak)) begin
			res.cat_peak = new_bytes[PEAK_W-1:0];
		end
		if (!new_total[BYTES_W-1] && (new_total[PEAK_W-1:0] > old_total_peak)) begin
			res.total_peak = new_total[PEAK_W-1:0];
		end
	end

endmodule

// File: tb/sv/category_usage_ledger_test.sv
// Self-checking testbench for category_usage_ledger: directed extremes, table fill
// and random traffic, with each result checked against a ledger kept in the bench.
// Depends on cul_pkg and the category_usage_ledger RTL.
module category_usage_ledger_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cul_pkg::*;

	localparam int unsigned SLOTS      = DEF_SLOTS;
	localparam int unsigned ID_POOL    = 40;
	localparam int unsigned QUIET_MAX  = 600;
	localparam int unsigned MAX_REPORT = 10;

	localparam logic [BYTES_W-1:0] D_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [BYTES_W-1:0] D_MIN  = 64'h8000_0000_0000_0000;
	localparam logic [BYTES_W-1:0] D_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [BYTES_W-1:0] D_FIVE = 64'h5555_5555_5555_5555;
	localparam logic [BYTES_W-1:0] D_TEN  = 64'hAAAA_AAAA_AAAA_AAAA;

	// One ledger report as the block should present it.
	typedef struct packed {
		status_t            st;
		logic [IDX_W-1:0]   idx;
		logic [BYTES_W-1:0] cat_bytes;
		logic [PEAK_W-1:0]  cat_peak;
		logic [BYTES_W-1:0] tot_bytes;
		logic [PEAK_W-1:0]  tot_peak;
	} ledger_report_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [ID_W-1:0]     category_id;
	logic [BYTES_W-1:0]  delta_bytes;
	logic                done;
	logic [1:0]          status;
	logic [IDX_W-1:0]    slot_index;
	logic [BYTES_W-1:0]  category_bytes;
	logic [PEAK_W-1:0]   category_peak;
	logic [BYTES_W-1:0]  total_bytes;
	logic [PEAK_W-1:0]   total_peak;

	category_usage_ledger i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.category_id    (category_id),
		.delta_bytes    (delta_bytes),
		.done           (done),
		.status         (status),
		.slot_index     (slot_index),
		.category_bytes (category_bytes),
		.category_peak  (category_peak),
		.total_bytes    (total_bytes),
		.total_peak     (total_peak)
	);

	// The bench's own copy of the ledger. Only claimed slots are ever looked at,
	// so the entries beyond ldg_used never need a value.
	logic [ID_W-1:0]    ldg_keys [SLOTS];
	logic [BYTES_W-1:0] ldg_count[SLOTS];
	logic [BYTES_W-1:0] ldg_peak [SLOTS];
	int unsigned        ldg_used;
	logic [BYTES_W-1:0] ldg_total;
	logic [BYTES_W-1:0] ldg_total_peak;

	// Reports still owed by the block, oldest first.
	ledger_report_t due_reports[$];

	int unsigned mismatches;
	int unsigned quiet_cycles;
	int unsigned idle_pct;
	int unsigned pool_reach;
	int unsigned pool_draws;
	logic [ID_W-1:0] id_pool[ID_POOL];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Returns the slot holding the id among the claimed ones, or -1 on a miss.
	function automatic int find_slot(input logic [ID_W-1:0] id);
		for (int k = 0; k < int'(ldg_used); k++) begin
			if (ldg_keys[k] == id)
				return k;
		end
		return -1;
	endfunction

	// Posts one transaction to the bench ledger and returns the report that the
	// block must give for it. Sums wrap at 64 bits; peaks are raised on a signed
	// comparison, so they start at zero and never turn negative.
	function automatic ledger_report_t ledger_post(input logic [ID_W-1:0] id,
			input logic [BYTES_W-1:0] delta);
		ledger_report_t r;
		int k;
		r = '0;
		if (delta == '0) begin
			r.st = ST_IGNORED;
		end else begin
			k = find_slot(id);
			if (k < 0 && ldg_used < SLOTS) begin
				k = int'(ldg_used);
				ldg_keys[k]  = id;
				ldg_count[k] = '0;
				ldg_peak[k]  = '0;
				ldg_used++;
			end
			if (k < 0) begin
				r.st = ST_DROPPED;
			end else begin
				ldg_count[k] = ldg_count[k] + delta;
				if ($signed(ldg_count[k]) > $signed(ldg_peak[k]))
					ldg_peak[k] = ldg_count[k];
				ldg_total = ldg_total + delta;
				if ($signed(ldg_total) > $signed(ldg_total_peak))
					ldg_total_peak = ldg_total;
				r.st        = ST_UPDATED;
				r.idx       = IDX_W'(k);
				r.cat_bytes = ldg_count[k];
				r.cat_peak  = ldg_peak[k][PEAK_W-1:0];
			end
		end
		r.tot_bytes = ldg_total;
		r.tot_peak  = ldg_total_peak[PEAK_W-1:0];
		return r;
	endfunction

	// Mostly small allocations and frees so that peaks keep moving, with some
	// full-width values and extremes to drive the counts round the wrap.
	function automatic logic [BYTES_W-1:0] pick_delta();
		logic [BYTES_W-1:0] m;
		int unsigned r;
		r = $urandom_range(0, 99);
		m = 64'($urandom_range(1, 4096));
		if (r < 5)
			return '0;
		if (r < 42)
			return m;
		if (r < 78)
			return -m;
		if (r < 83) begin
			case ($urandom_range(0, 3))
				0:       return D_MAX;
				1:       return D_MIN;
				2:       return D_ONES;
				default: return 64'd1;
			endcase
		end
		return {$urandom, $urandom};
	endfunction

	// Ids come mostly from a pool whose reachable part grows as the run goes
	// on, so the table fills gradually; a few are fresh random ids.
	function automatic logic [ID_W-1:0] pick_id();
		pool_draws++;
		if (pool_draws % 6 == 0 && pool_reach < ID_POOL)
			pool_reach++;
		if ($urandom_range(0, 99) < 8)
			return ID_W'($urandom);
		return id_pool[$urandom_range(0, pool_reach - 1)];
	endfunction

	function automatic logic [ID_W-1:0] fresh_id();
		logic [ID_W-1:0] id;
		do
			id = ID_W'($urandom);
		while (find_slot(id) >= 0);
		return id;
	endfunction

	// Offers one transaction and holds it until the block takes it. start is
	// only lowered when a gap follows, so back-to-back transactions keep it
	// high across the accepting edge.
	task automatic send_item(input logic [ID_W-1:0] id, input logic [BYTES_W-1:0] delta);
		int unsigned gap;
		start       <= 1'b1;
		category_id <= id;
		delta_bytes <= delta;
		do
			@(posedge clk);
		while (busy);
		due_reports.push_back(ledger_post(id, delta));
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The sender holds off until every owed report has arrived.
	task automatic drain();
		start <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
	endtask

	// Random transactions until n of them carried a non-zero delta.
	task automatic random_items(input int unsigned n);
		int unsigned sent;
		logic [BYTES_W-1:0] d;
		sent = 0;
		while (sent < n) begin
			d = pick_delta();
			send_item(pick_id(), d);
			if (d != '0)
				sent++;
		end
	endtask

	// Extremes of both fields, both wraps, and zero deltas on an empty table
	// and on a claimed id.
	task automatic test_directed_extremes();
		idle_pct = 20;
		send_item(16'h0000, '0);
		send_item(16'hFFFF, D_MAX);
		send_item(16'hFFFF, 64'd1);
		send_item(16'h0000, D_MIN);
		send_item(16'h0000, D_ONES);
		send_item(16'hFFFF, '0);
		send_item(16'h5555, D_FIVE);
		send_item(16'hAAAA, D_TEN);
		send_item(16'h5555, D_ONES);
		send_item(16'hAAAA, D_MAX);
		send_item(16'hFFFF, D_MIN);
	endtask

	task automatic test_sender_idle_light();
		idle_pct = 20;
		random_items(460);
	endtask

	// Claims whatever slots are left, then offers new ids to a full table: they
	// must be dropped, a zero delta must still read as ignored, and hits on the
	// first and last slots must still update.
	task automatic test_table_full();
		idle_pct = 20;
		while (ldg_used < SLOTS)
			send_item(fresh_id(), 64'($urandom_range(1, 4096)));
		send_item(fresh_id(), D_MAX);
		send_item(fresh_id(), D_MIN);
		send_item(fresh_id(), '0);
		send_item(ldg_keys[SLOTS-1], 64'd7);
		send_item(fresh_id(), 64'd1);
		send_item(ldg_keys[0], D_ONES);
	endtask

	task automatic test_sender_idle_heavy();
		idle_pct = 77;
		random_items(460);
	endtask

	// No idling at all, with one full pause halfway.
	task automatic test_back_to_back();
		idle_pct = 0;
		random_items(230);
		drain();
		random_items(230);
	endtask

	task automatic note_mismatch(input string what, input logic [BYTES_W-1:0] want,
			input logic [BYTES_W-1:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORT)
			$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	task automatic compare_field(input string what, input logic [BYTES_W-1:0] want,
			input logic [BYTES_W-1:0] got);
		if (got !== want)
			note_mismatch(what, want, got);
	endtask

	// Result checker and watchdog. Everything is sampled at the rising edge,
	// before the block's own updates for that edge land. The watchdog counts
	// cycles in which neither a transaction nor a result is taken.
	ledger_report_t want;
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (done === 1'b1) begin
				if (due_reports.size() == 0) begin
					note_mismatch("unexpected result, total_bytes", '0, total_bytes);
				end else begin
					want = due_reports.pop_front();
					compare_field("status", 64'(want.st), 64'(status));
					compare_field("slot_index", 64'(want.idx), 64'(slot_index));
					compare_field("category_bytes", want.cat_bytes, category_bytes);
					compare_field("category_peak", 64'(want.cat_peak), 64'(category_peak));
					compare_field("total_bytes", want.tot_bytes, total_bytes);
					compare_field("total_peak", 64'(want.tot_peak), 64'(total_peak));
				end
			end
			if (done === 1'b1 || (start === 1'b1 && busy === 1'b0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("watchdog: %0d cycles without progress", quiet_cycles);
				$display("FAIL category_usage_ledger");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		category_id = '0;
		delta_bytes = '0;
		mismatches     = 0;
		quiet_cycles   = 0;
		idle_pct       = 0;
		ldg_used       = 0;
		ldg_total      = '0;
		ldg_total_peak = '0;
		pool_reach     = 2;
		pool_draws     = 0;
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		for (int k = 2; k < ID_POOL; k++)
			id_pool[k] = ID_W'($urandom);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_sender_idle_light();
		drain();
		test_table_full();
		test_sender_idle_heavy();
		test_back_to_back();

		// Wind down: let the last results arrive, then keep watching for any
		// result that the block should not have sent.
		drain();
		repeat (SLOTS + 8) @(posedge clk);
		if (due_reports.size() != 0)
			note_mismatch("results never arrived, count", '0, 64'(due_reports.size()));
		if (mismatches == 0)
			$display("PASS category_usage_ledger");
		else
			$display("FAIL category_usage_ledger");
		$finish;
	end

endmodule
